// File: hw/rtl/frc_pkg.sv
// Shared types and constants for the framed command receiver.
package frc_pkg;

    // Per-byte result codes.
    typedef enum logic [2:0] {
        ST_DISCARD = 3'd0,
        ST_FRAME   = 3'd1,
        ST_GOOD    = 3'd2,
        ST_CRCERR  = 3'd3,
        ST_REJECT  = 3'd4,
        ST_WRAP    = 3'd5
    } t_status;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_RX_ENABLE   = 3'd0,
        CFG_START_BYTE  = 3'd1,
        CFG_SECOND_BYTE = 3'd2,
        CFG_HOST_ADDR   = 3'd3,
        CFG_OWN_ADDR    = 3'd4
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Header positions within a frame.
    localparam logic [BYTE_W-1:0] POS_IDLE   = 8'd0;
    localparam logic [BYTE_W-1:0] POS_SECOND = 8'd1;
    localparam logic [BYTE_W-1:0] POS_HOST   = 8'd2;
    localparam logic [BYTE_W-1:0] POS_OWN    = 8'd3;
    localparam logic [BYTE_W-1:0] POS_CMD    = 8'd4;
    localparam logic [BYTE_W-1:0] POS_LEN    = 8'd5;

    // Offsets of the CRC bytes after the payload.
    localparam logic [BYTE_W:0] CRC_HI_OFS = 9'd6;
    localparam logic [BYTE_W:0] CRC_LO_OFS = 9'd7;

    // Configuration register contents.
    typedef struct packed {
        logic              rx_enable;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] second_byte;
        logic [BYTE_W-1:0] host_addr;
        logic [BYTE_W-1:0] own_addr;
    } t_cfg;

    // One result transaction.
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] byte_position;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] payload_length;
    } t_result;

endpackage

// File: hw/rtl/frc_cfg_regs.sv
// Configuration register file of the framed command receiver.
module frc_cfg_regs
    import frc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Write one register per transaction; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RX_ENABLE:   r_cfg.rx_enable   <= i_cfg_data[0];
                CFG_START_BYTE:  r_cfg.start_byte  <= i_cfg_data;
                CFG_SECOND_BYTE: r_cfg.second_byte <= i_cfg_data;
                CFG_HOST_ADDR:   r_cfg.host_addr   <= i_cfg_data;
                CFG_OWN_ADDR:    r_cfg.own_addr    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/frc_crc16_byte.sv
// One-byte CRC-16/MODBUS update (reflected polynomial), purely combinational.
module frc_crc16_byte
    import frc_pkg::*;
(
    input  logic [CRC_W-1:0]  i_crc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [CRC_W-1:0]  o_crc
);

    // Eight shift steps, one per data bit, least significant bit first.
    always_comb begin
        logic [CRC_W-1:0] v_crc;
        v_crc = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < BYTE_W; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

// File: hw/rtl/frc_frame_fsm.sv
// Frame tracking state and per-byte decision logic with the running CRC.
module frc_frame_fsm
    import frc_pkg::*;
#(
    parameter int unsigned BUFFER_SIZE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam logic [BYTE_W-1:0] WRAP_POS = BYTE_W'(BUFFER_SIZE - 1);

    logic [BYTE_W-1:0] r_pos,    n_pos;
    logic [CRC_W-1:0]  r_crc,    n_crc;
    logic [BYTE_W-1:0] r_crc_hi, n_crc_hi;
    logic [BYTE_W-1:0] r_cmd,    n_cmd;
    logic [BYTE_W-1:0] r_len,    n_len;

    logic              w_is_start;
    logic [CRC_W-1:0]  w_crc_seed;
    logic [CRC_W-1:0]  w_crc_next;
    logic [BYTE_W:0]   w_pos_crc_hi;
    logic [BYTE_W:0]   w_pos_crc_lo;
    t_status           w_status;

    assign w_is_start   = (i_byte == i_cfg.start_byte);
    assign w_crc_seed   = w_is_start ? CRC_INIT : r_crc;
    assign w_pos_crc_hi = {1'b0, r_len} + CRC_HI_OFS;
    assign w_pos_crc_lo = {1'b0, r_len} + CRC_LO_OFS;

    frc_crc16_byte u_crc (
        .i_crc  (w_crc_seed),
        .i_byte (i_byte),
        .o_crc  (w_crc_next)
    );

    // Decide the byte's fate and the state it leaves behind.
    always_comb begin
        logic              v_advance;
        logic [BYTE_W-1:0] v_base;
        logic [BYTE_W-1:0] v_pos_inc;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_cmd     = r_cmd;
        n_len     = r_len;
        w_status  = ST_FRAME;
        v_advance = 1'b1;
        v_base    = r_pos;

        if (!i_cfg.rx_enable) begin
            w_status  = ST_DISCARD;
            v_advance = 1'b0;
        end else if (w_is_start) begin
            // A start byte restarts the frame wherever it appears.
            v_base = POS_IDLE;
            n_crc  = w_crc_next;
            n_cmd  = '0;
            n_len  = '0;
        end else if (r_pos == POS_IDLE) begin
            w_status  = ST_DISCARD;
            v_advance = 1'b0;
        end else if (r_pos == POS_SECOND || r_pos == POS_HOST || r_pos == POS_OWN) begin
            // Header markers and ids must match or the frame is dropped.
            if ((r_pos == POS_SECOND && i_byte != i_cfg.second_byte) ||
                (r_pos == POS_HOST   && i_byte != i_cfg.host_addr)   ||
                (r_pos == POS_OWN    && i_byte != i_cfg.own_addr)) begin
                n_pos     = POS_IDLE;
                n_crc     = CRC_INIT;
                w_status  = ST_REJECT;
                v_advance = 1'b0;
            end else begin
                n_crc = w_crc_next;
            end
        end else if (r_pos == POS_CMD) begin
            n_cmd = i_byte;
            n_crc = w_crc_next;
        end else if (r_pos == POS_LEN) begin
            n_len = i_byte;
            n_crc = w_crc_next;
        end else if ({1'b0, r_pos} == w_pos_crc_hi) begin
            // High CRC byte is held, not folded into the CRC.
            n_crc_hi = i_byte;
        end else if ({1'b0, r_pos} == w_pos_crc_lo) begin
            w_status  = ({r_crc_hi, i_byte} == r_crc) ? ST_GOOD : ST_CRCERR;
            n_pos     = POS_IDLE;
            n_crc     = CRC_INIT;
            v_advance = 1'b0;
        end else begin
            n_crc = w_crc_next;
        end

        // Advance the position and wrap at the buffer limit.
        v_pos_inc = v_base + 8'd1;
        if (v_advance) begin
            if (v_pos_inc == WRAP_POS) begin
                n_pos    = POS_IDLE;
                n_crc    = CRC_INIT;
                w_status = ST_WRAP;
            end else begin
                n_pos = v_pos_inc;
            end
        end
    end

    // Frame state, updated once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_IDLE;
            r_crc    <= CRC_INIT;
            r_crc_hi <= '0;
            r_cmd    <= '0;
            r_len    <= '0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
        end
    end

    assign o_result.status         = w_status;
    assign o_result.byte_position  = r_pos;
    assign o_result.data_byte      = i_byte;
    assign o_result.command_code   = n_cmd;
    assign o_result.payload_length = n_len;

endmodule

// File: hw/rtl/framed_command_receiver_crc16.sv
// Top level of the framed command receiver with CRC-16/MODBUS check.
//
// Each received byte gives exactly one result: a status code, the byte's position within
// the current frame, the byte itself, and the command and length bytes of the frame so far.
// A byte enters an input register; when the result register is free, the frame logic and
// the one-byte CRC update run on it and load the result register. One byte is taken every
// cycle, as long as the output side keeps draining. That rate is set by the per-byte loop
// through the frame state and the running CRC register.
// A frame is start byte, second start byte, sender id, receiver id, command, length L, L
// payload bytes and the CRC, high byte first. A frame whose position would reach
// BUFFER_SIZE - 1 wraps and reports overflow. Configuration writes take effect at once.
// The user must make them only while no byte is in flight; the block does not enforce this.
// There is no clearing pass after reset.
module framed_command_receiver_crc16
    import frc_pkg::*;
#(
    parameter int unsigned BUFFER_SIZE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Receive byte stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [7:0] byte_position, [15:8] data_byte,
                                                 // [23:16] command_code,
                                                 // [31:24] payload_length
    output logic [2:0]           m_axis_tuser,   // [2:0] status
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_out_free;
    logic              w_fire;
    t_cfg              w_cfg;
    t_result           w_result;

    assign o_cfg_ready = 1'b1;

    frc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // The registered byte is processed whenever the result register can take it.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    frc_frame_fsm #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {r_out.payload_length, r_out.command_code,
                            r_out.data_byte, r_out.byte_position};

`ifndef SYNTH
    // A processed byte always leaves a result in the output register.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> m_axis_tvalid)
        else $error("processed byte produced no result");

    // A frame can only end on or after its eighth byte.
    a_frame_end_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_GOOD || m_axis_tuser == ST_CRCERR))
        |-> (m_axis_tdata[7:0] >= 8'd7))
        else $error("frame end reported too early in the frame");

    // Header rejection only happens on the marker and id bytes.
    a_reject_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_REJECT)
        |-> (m_axis_tdata[7:0] == POS_SECOND || m_axis_tdata[7:0] == POS_HOST ||
             m_axis_tdata[7:0] == POS_OWN))
        else $error("header rejection outside the header");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the framed command receiver with its own frame and CRC predictor.
module tb_top;
    import frc_pkg::*;

    localparam int unsigned FRAME_BUFFER  = 256;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;

    // Ways in which a generated frame can be spoilt.
    typedef enum {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_SECOND,
        FAULT_HOST,
        FAULT_OWN,
        FAULT_CUT
    } t_fault;

    // Tracks the frame state of the receiver and holds the results still owed by it.
    class frame_tracker;
        localparam int REPORT_LIMIT = 10;

        t_cfg        cfg;
        int unsigned buffer_size;
        logic [7:0]  position;
        logic [7:0]  crc_high;
        logic [7:0]  command;
        logic [7:0]  length;
        logic [15:0] crc;
        t_result     expected_results[$];
        int          mismatches;

        function new(int unsigned size);
            buffer_size = size;
            cfg         = '0;
            position    = '0;
            crc         = CRC_INIT;
            crc_high    = '0;
            command     = '0;
            length      = '0;
            mismatches  = 0;
        endfunction

        // One byte through the reflected CRC-16/MODBUS register.
        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void load_register(t_cfg_idx idx, logic [7:0] val);
            case (idx)
                CFG_RX_ENABLE:   cfg.rx_enable   = val[0];
                CFG_START_BYTE:  cfg.start_byte  = val;
                CFG_SECOND_BYTE: cfg.second_byte = val;
                CFG_HOST_ADDR:   cfg.host_addr   = val;
                CFG_OWN_ADDR:    cfg.own_addr    = val;
                default: ;
            endcase
        endfunction

        // Works out the result of one accepted byte and queues it.
        function void take_byte(logic [7:0] b);
            logic [7:0] pos_in;
            t_status    st;
            bit         advance;
            bit         header_ok;
            t_result    r;
            pos_in  = position;
            st      = ST_FRAME;
            advance = 1'b1;
            if (!cfg.rx_enable) begin
                st      = ST_DISCARD;
                advance = 1'b0;
            end else if (b == cfg.start_byte) begin
                // A start byte restarts the frame wherever it appears.
                position = '0;
                crc      = crc_step(CRC_INIT, b);
                command  = '0;
                length   = '0;
            end else if (pos_in == POS_IDLE) begin
                st      = ST_DISCARD;
                advance = 1'b0;
            end else if (pos_in == POS_SECOND || pos_in == POS_HOST || pos_in == POS_OWN) begin
                header_ok = (pos_in == POS_SECOND) ? (b == cfg.second_byte) :
                            (pos_in == POS_HOST)   ? (b == cfg.host_addr) :
                                                     (b == cfg.own_addr);
                if (header_ok) begin
                    crc = crc_step(crc, b);
                end else begin
                    position = '0;
                    crc      = CRC_INIT;
                    st       = ST_REJECT;
                    advance  = 1'b0;
                end
            end else if (pos_in == POS_CMD) begin
                command = b;
                crc     = crc_step(crc, b);
            end else if (pos_in == POS_LEN) begin
                length = b;
                crc    = crc_step(crc, b);
            end else if ({1'b0, pos_in} == {1'b0, length} + CRC_HI_OFS) begin
                crc_high = b;
            end else if ({1'b0, pos_in} == {1'b0, length} + CRC_LO_OFS) begin
                st       = ({crc_high, b} == crc) ? ST_GOOD : ST_CRCERR;
                position = '0;
                crc      = CRC_INIT;
                advance  = 1'b0;
            end else begin
                crc = crc_step(crc, b);
            end

            // The position wraps one short of the buffer size.
            if (advance) begin
                position = position + 8'd1;
                if (position == 8'(buffer_size - 1)) begin
                    position = '0;
                    crc      = CRC_INIT;
                    st       = ST_WRAP;
                end
            end

            r.status         = st;
            r.byte_position  = pos_in;
            r.data_byte      = b;
            r.command_code   = command;
            r.payload_length = length;
            expected_results.push_back(r);
        endfunction

        function void compare_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d pos %0d data %02h cmd %02h len %02h",
                             got.status, got.byte_position, got.data_byte,
                             got.command_code, got.payload_length);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.byte_position !== want.byte_position ||
                got.data_byte !== want.data_byte || got.command_code !== want.command_code ||
                got.payload_length !== want.payload_length) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch: expected status %0d pos %0d data %02h cmd %02h len %02h",
                             want.status, want.byte_position, want.data_byte,
                             want.command_code, want.payload_length);
                    $display("          actual   status %0d pos %0d data %02h cmd %02h len %02h",
                             got.status, got.byte_position, got.data_byte,
                             got.command_code, got.payload_length);
                end
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [BYTE_W-1:0]    i_cfg_data    = '0;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_left     = 0;
    int           sent_items    = 0;
    int unsigned  cycle_count   = 0;
    t_cfg         cur_cfg       = '0;
    frame_tracker tracker;

    framed_command_receiver_crc16 #(
        .BUFFER_SIZE(FRAME_BUFFER)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Result side: random back-pressure, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watch every transaction: results first, then bytes and register writes.
    always @(posedge i_clk) begin : watch
        t_result got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status         = t_status'(m_axis_tuser);
                got.byte_position  = m_axis_tdata[7:0];
                got.data_byte      = m_axis_tdata[15:8];
                got.command_code   = m_axis_tdata[23:16];
                got.payload_length = m_axis_tdata[31:24];
                tracker.compare_result(got);
            end
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_byte(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                tracker.load_register(t_cfg_idx'(i_cfg_index), i_cfg_data);
        end
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] other_byte(input logic [7:0] avoid);
        logic [7:0] v;
        do v = 8'($urandom); while (v == avoid);
        return v;
    endfunction

    // Offers one byte after a random gap and waits for its transaction.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Builds a frame for the current setting, spoils it as asked and sends it.
    task automatic send_frame(input int len, input t_fault fault);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int          keep;
        frame = {cur_cfg.start_byte, cur_cfg.second_byte, cur_cfg.host_addr,
                 cur_cfg.own_addr, other_byte(cur_cfg.start_byte), 8'(len)};
        repeat (len) frame.push_back(other_byte(cur_cfg.start_byte));
        crc = CRC_INIT;
        foreach (frame[i]) crc = frame_tracker::crc_step(crc, frame[i]);
        frame.push_back(crc[15:8]);
        frame.push_back(crc[7:0]);
        case (fault)
            FAULT_CRC:    frame[frame.size() - 1] ^= 8'h01 << $urandom_range(7);
            FAULT_SECOND: frame[1] = other_byte(frame[1]);
            FAULT_HOST:   frame[2] = other_byte(frame[2]);
            FAULT_OWN:    frame[3] = other_byte(frame[3]);
            FAULT_CUT: begin
                keep  = $urandom_range(1, frame.size() - 1);
                frame = frame[0:keep-1];
            end
            default: ;
        endcase
        foreach (frame[i]) send_byte(frame[i]);
        sent_items += frame.size();
    endtask

    // Stops offering bytes until every owed result has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_results.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_cfg(input t_cfg c);
        write_reg(CFG_RX_ENABLE, {7'd0, c.rx_enable});
        write_reg(CFG_START_BYTE, c.start_byte);
        write_reg(CFG_SECOND_BYTE, c.second_byte);
        write_reg(CFG_HOST_ADDR, c.host_addr);
        write_reg(CFG_OWN_ADDR, c.own_addr);
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // Mostly whole frames of short length, some spoilt frames and some stray bytes.
    task automatic random_traffic(input int target);
        int goal;
        int pick;
        int len;
        goal = sent_items + target;
        while (sent_items < goal) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(12);
            if (pick < 70)
                send_frame(len, FAULT_NONE);
            else if (pick < 88)
                send_frame(len, t_fault'($urandom_range(FAULT_CRC, FAULT_CUT)));
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
    endtask

    initial begin
        t_cfg setup;
        tracker = new(FRAME_BUFFER);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Receiver is disabled out of reset, so these bytes are discarded.
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_drained();

        // Directed frames: stray byte while idle, good frame, restart then bad marker, bad CRC.
        setup = '{rx_enable: 1'b1, start_byte: 8'h5A, second_byte: 8'hA5,
                  host_addr: 8'h01, own_addr: 8'h02};
        program_cfg(setup);
        send_byte(8'h33);
        send_frame(0, FAULT_NONE);
        send_byte(8'h5A);
        send_byte(8'h5A);
        send_byte(8'h77);
        send_frame(0, FAULT_CRC);
        wait_drained();

        // Random setting, sender idling lightly and receiver heavily.
        send_idle_pct      = 19;
        recv_idle_pct      = 57;
        setup.start_byte   = 8'($urandom);
        setup.second_byte  = other_byte(setup.start_byte);
        setup.host_addr    = other_byte(setup.start_byte);
        setup.own_addr     = other_byte(setup.start_byte);
        program_cfg(setup);
        random_traffic(40);
        wait_drained();

        // Low start byte with all-ones markers; the longest length byte runs into the wrap.
        send_idle_pct = 57;
        recv_idle_pct = 19;
        setup = '{rx_enable: 1'b1, start_byte: 8'h00, second_byte: 8'hFF,
                  host_addr: 8'hFF, own_addr: 8'hFF};
        program_cfg(setup);
        send_frame(255, FAULT_NONE);
        random_traffic(40);
        wait_drained();

        // Short stretch with the receiver switched off.
        setup.rx_enable = 1'b0;
        program_cfg(setup);
        repeat (12) send_byte(8'($urandom));
        wait_drained();

        // High start byte with all-zero markers, no idling at all.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        setup = '{rx_enable: 1'b1, start_byte: 8'hFF, second_byte: 8'h00,
                  host_addr: 8'h00, own_addr: 8'h00};
        program_cfg(setup);
        // The longest frame that still completes before the wrap.
        send_frame(247, FAULT_NONE);

        // Long receiver hold-off while bytes keep coming, then a full drain.
        hold_left = 80;
        send_frame(30, FAULT_NONE);
        wait_drained();
        random_traffic(40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
